// ===== hw/rtl/diff_drive_odometry_integrator_core_assert.svh =====
// ----------------------------------------------------------------------------
// odometry core assertion macros
// shared helpers for concurrent checks with asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define DDO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DDO_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `DDO_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== hw/rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// shared constants, types and the arc tangent table of the odometry core
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicStepW = $clog2(CordicSteps);

  localparam int AngW  = 36;  // q.30 angle inside the rotator
  localparam int CsW   = 34;  // q.30 sine and cosine
  localparam int DivW  = 37;  // divider magnitude width
  localparam int DivSW = DivW + 1;
  localparam int MulAW = 34;
  localparam int MulBW = 36;
  localparam int ProdW = MulAW + MulBW;
  localparam int PosW  = 44;
  localparam int CfgIdxW = 8;

  localparam logic signed [AngW-1:0]  PiQ30     = 36'sd3373259426;
  localparam logic signed [AngW-1:0]  HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [AngW-1:0]  TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [CsW-1:0]   GainQ30   = 34'sd652032874;
  localparam logic signed [DivSW-1:0] TwoPiQ16  = 38'sd411775;

  localparam logic [CfgIdxW-1:0] CfgWheelSep = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeStep = 8'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_ALPHA_W,
    ST_SC0,
    ST_SC0_W,
    ST_RAD,
    ST_RAD_W,
    ST_ARM,
    ST_HEAD,
    ST_HEAD_W,
    ST_SC1,
    ST_SC1_W,
    ST_MULX,
    ST_MULX_W,
    ST_MULY,
    ST_MULY_W,
    ST_DONE
  } ddo_state_e;

  // atan(2^-i) in q.30, rounded
  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [AngW-1:0] t;
    case (idx)
      5'd0:    t = 36'sd843314857;
      5'd1:    t = 36'sd497837829;
      5'd2:    t = 36'sd263043837;
      5'd3:    t = 36'sd133525159;
      5'd4:    t = 36'sd67021687;
      5'd5:    t = 36'sd33543516;
      5'd6:    t = 36'sd16775851;
      5'd7:    t = 36'sd8388437;
      5'd8:    t = 36'sd4194283;
      5'd9:    t = 36'sd2097149;
      5'd10:   t = 36'sd1048576;
      5'd11:   t = 36'sd524288;
      5'd12:   t = 36'sd262144;
      5'd13:   t = 36'sd131072;
      5'd14:   t = 36'sd65536;
      5'd15:   t = 36'sd32768;
      5'd16:   t = 36'sd16384;
      5'd17:   t = 36'sd8192;
      5'd18:   t = 36'sd4096;
      5'd19:   t = 36'sd2048;
      5'd20:   t = 36'sd1024;
      5'd21:   t = 36'sd512;
      5'd22:   t = 36'sd256;
      5'd23:   t = 36'sd128;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/ddo_div.sv =====
// ----------------------------------------------------------------------------
// ddo_div
// serial restoring signed divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ddo_div
  import ddo_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DivSW-1:0] dividend_i,
  input  logic signed [DivSW-1:0] divisor_i,
  output logic                    done_o,
  output logic signed [DivSW-1:0] quot_o,
  output logic signed [DivSW-1:0] rem_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW:0]   rem_q;
  logic [DivW-1:0] quo_q;
  logic [DivW-1:0] den_q;
  logic            qneg_q;
  logic            rneg_q;

  logic [DivSW-1:0] n_abs;
  logic [DivSW-1:0] d_abs;
  logic [DivW:0]    trial;
  logic             fits;

  assign n_abs = dividend_i[DivSW-1] ? DivSW'(-dividend_i) : DivSW'(dividend_i);
  assign d_abs = divisor_i[DivSW-1] ? DivSW'(-divisor_i) : DivSW'(divisor_i);
  assign trial = {rem_q[DivW-1:0], quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= n_abs[DivW-1:0];
      den_q  <= d_abs[DivW-1:0];
      qneg_q <= dividend_i[DivSW-1] ^ divisor_i[DivSW-1];
      rneg_q <= dividend_i[DivSW-1];
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign rem_o  = rneg_q ? -$signed({1'b0, rem_q[DivW-1:0]})
                         : $signed({1'b0, rem_q[DivW-1:0]});

endmodule

// ===== hw/rtl/ddo_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_mul
// serial shift-add signed multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module ddo_mul
  import ddo_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic                    done_o,
  output logic signed [ProdW-1:0] prod_o
);

  localparam int CntW = $clog2(MulBW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [MulAW:0]   hi_q;
  logic [MulBW-1:0] lo_q;
  logic [MulAW-1:0] ma_q;
  logic             neg_q;

  logic [MulAW-1:0] a_abs;
  logic [MulBW-1:0] b_abs;
  logic [MulAW:0]   sum;
  logic [ProdW-1:0] mag;

  assign a_abs = a_i[MulAW-1] ? MulAW'(-a_i) : MulAW'(a_i);
  assign b_abs = b_i[MulBW-1] ? MulBW'(-b_i) : MulBW'(b_i);
  assign sum   = lo_q[0] ? (hi_q + {1'b0, ma_q}) : hi_q;
  assign mag   = {hi_q[MulAW-1:0], lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MulBW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q  <= '0;
      lo_q  <= b_abs;
      ma_q  <= a_abs;
      neg_q <= a_i[MulAW-1] ^ b_i[MulBW-1];
    end else if (busy_q) begin
      hi_q <= {1'b0, sum[MulAW:1]};
      lo_q <= {sum[0], lo_q[MulBW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -$signed(mag) : $signed(mag);

endmodule

// ===== hw/rtl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// rotation-mode cordic, one micro-rotation per cycle after quadrant folding
// ----------------------------------------------------------------------------
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [19:0]    angle_i,
  output logic                  done_o,
  output logic signed [CsW-1:0] sin_o,
  output logic signed [CsW-1:0] cos_o
);

  logic                   busy_q;
  logic                   done_q;
  logic [CordicStepW-1:0] step_q;
  logic signed [CsW-1:0]  x_q;
  logic signed [CsW-1:0]  y_q;
  logic signed [AngW-1:0] z_q;
  logic                   neg_q;

  logic signed [AngW-1:0] a0;
  logic signed [AngW-1:0] a1;
  logic signed [AngW-1:0] a2;
  logic                   fold;
  logic signed [CsW-1:0]  xs;
  logic signed [CsW-1:0]  ys;
  logic signed [AngW-1:0] t;

  // q3.16 to q.30, wrap into one turn, then fold into the right half plane
  always_comb begin
    a0 = {{(AngW - 34){angle_i[19]}}, angle_i, 14'b0};
    a1 = a0;
    if (a0 > PiQ30) begin
      a1 = a0 - TwoPiQ30;
    end else if (a0 < -PiQ30) begin
      a1 = a0 + TwoPiQ30;
    end
    a2   = a1;
    fold = 1'b0;
    if (a1 > HalfPiQ30) begin
      a2   = a1 - PiQ30;
      fold = 1'b1;
    end else if (a1 < -HalfPiQ30) begin
      a2   = a1 + PiQ30;
      fold = 1'b1;
    end
  end

  assign xs = x_q >>> step_q;
  assign ys = y_q >>> step_q;
  assign t  = atan_q30(5'(step_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == CordicStepW'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= GainQ30;
      y_q   <= '0;
      z_q   <= a2;
      neg_q <= fold;
    end else if (busy_q) begin
      if (!z_q[AngW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - t;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + t;
      end
    end
  end

  assign done_o = done_q;
  assign sin_o  = neg_q ? -y_q : y_q;
  assign cos_o  = neg_q ? -x_q : x_q;

endmodule

// ===== hw/rtl/diff_drive_odometry_integrator_core.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_core
// differential-drive odometry: arc integration of a planar pose per tick
// ----------------------------------------------------------------------------
// channel  | direction | contents
// s_axis   | in        | tdata: left_speed, right_speed
// m_axis   | out       | tdata: pos_x, pos_y, heading; tuser: saturated
// cfg      | in        | register index and write data, always ready
//
// a turning tick runs three divisions on the serial divider, two products on
// the shared shift-add multiplier and two passes of the 16-step cordic; a
// straight tick runs one division, one cordic pass and the two products.
// s_axis_tready is high only while the sequencer is idle.
// the result waits in an output register; a stalled m_axis holds the next
// tick in its last state until the register is free. rst_ni clears the pose.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_integrator_core_assert.svh"

module diff_drive_odometry_integrator_core
  import ddo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // left_speed, right_speed
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [87:0]        m_axis_tdata,   // pos_x, pos_y, heading, zero pad
  output logic               m_axis_tuser,   // saturated
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam logic signed [ProdW-1:0] RndStraight = 70'sd1 <<< 41;
  localparam logic signed [ProdW-1:0] RndTurn     = 70'sd1 <<< 29;

  ddo_state_e state_q, state_d;

  logic [15:0] ws_q;
  logic [15:0] ts_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic signed [19:0] heading_q;
  logic               sat_q;
  logic               m_valid_q;
  logic [87:0]        m_data_q;
  logic               m_user_q;

  logic signed [32:0]       dl_q;
  logic signed [32:0]       dr_q;
  logic signed [DivSW-1:0]  alpha_q;
  logic signed [DivSW-1:0]  radius_q;
  logic signed [31:0]       arm_q;
  logic                     straight_q;
  logic signed [CsW-1:0]    s0_q;
  logic signed [CsW-1:0]    c0_q;

  logic                    div_start, div_done;
  logic signed [DivSW-1:0] div_n, div_d, div_quot, div_rem;
  logic                    cor_start, cor_done;
  logic signed [CsW-1:0]   cor_sin, cor_cos;
  logic                    mul_start, mul_done;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_prod;

  logic [15:0]             ws_eff;
  logic                    in_acc;
  logic                    out_load;
  logic signed [PosW-1:0]  arm_sum;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [PosW-1:0]  delta;
  logic signed [PosW-1:0]  pos_new;
  logic [32:0]             arm_cl;
  logic [32:0]             pos_cl;

  // {saturated, value}
  function automatic logic [32:0] clamp32(input logic signed [PosW-1:0] v);
    logic [32:0] r;
    if (v > PosW'(64'sd2147483647)) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < PosW'(-64'sd2147483648)) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  assign ws_eff        = (ws_q == '0) ? 16'd1 : ws_q;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  assign arm_sum = PosW'(radius_q) + PosW'($signed({1'b0, ws_eff, 3'b000}));
  assign arm_cl  = clamp32(arm_sum);

  // round half up at full product width, then move by the scaled product
  assign prod_rnd = mul_prod + (straight_q ? RndStraight : RndTurn);
  assign delta    = PosW'(prod_rnd >>> (straight_q ? 42 : 30));

  always_comb begin
    pos_new = PosW'(x_q) + delta;
    if (state_q == ST_MULY_W) begin
      pos_new = straight_q ? (PosW'(y_q) + delta) : (PosW'(y_q) - delta);
    end
  end
  assign pos_cl = clamp32(pos_new);

  // sequencer and unit operand selection
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    cor_start = 1'b0;
    mul_start = 1'b0;
    div_n     = '0;
    div_d     = TwoPiQ16;
    mul_a     = straight_q ? MulAW'(dl_q) : MulAW'(arm_q);
    mul_b     = straight_q ? MulBW'(c0_q) : (MulBW'(cor_sin) - MulBW'(s0_q));
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_ALPHA;
      end
      ST_ALPHA: begin
        div_start = 1'b1;
        state_d   = ST_ALPHA_W;
      end
      ST_ALPHA_W: begin
        if (div_done) state_d = ST_SC0;
      end
      ST_SC0: begin
        cor_start = 1'b1;
        state_d   = ST_SC0_W;
      end
      ST_SC0_W: begin
        if (cor_done) state_d = straight_q ? ST_MULX : ST_RAD;
      end
      ST_RAD: begin
        div_start = 1'b1;
        state_d   = ST_RAD_W;
      end
      ST_RAD_W: begin
        if (div_done) state_d = ST_ARM;
      end
      ST_ARM: begin
        state_d = ST_HEAD;
      end
      ST_HEAD: begin
        div_start = 1'b1;
        state_d   = ST_HEAD_W;
      end
      ST_HEAD_W: begin
        if (div_done) state_d = ST_SC1;
      end
      ST_SC1: begin
        cor_start = 1'b1;
        state_d   = ST_SC1_W;
      end
      ST_SC1_W: begin
        if (cor_done) state_d = ST_MULX;
      end
      ST_MULX: begin
        mul_start = 1'b1;
        state_d   = ST_MULX_W;
      end
      ST_MULX_W: begin
        if (mul_done) state_d = ST_MULY;
      end
      ST_MULY: begin
        mul_start = 1'b1;
        state_d   = ST_MULY_W;
      end
      ST_MULY_W: begin
        if (mul_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    case (state_q)
      ST_ALPHA: begin
        div_n = DivSW'(dr_q) - DivSW'(dl_q);
        div_d = DivSW'($signed({1'b0, ws_eff}));
      end
      ST_RAD: begin
        div_n = DivSW'(dl_q) <<< 4;
        div_d = alpha_q;
      end
      ST_HEAD: begin
        div_n = DivSW'(heading_q) + alpha_q;
        div_d = TwoPiQ16;
      end
      default: begin
        div_n = '0;
      end
    endcase

    if (state_q == ST_MULY) begin
      mul_b = straight_q ? MulBW'(s0_q) : (MulBW'(cor_cos) - MulBW'(c0_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q      <= 16'd4096;
      ts_q      <= 16'd3277;
      x_q       <= '0;
      y_q       <= '0;
      heading_q <= '0;
      sat_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgWheelSep: ws_q <= cfg_data_i;
          CfgTimeStep: ts_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) sat_q <= 1'b0;
      if ((state_q == ST_ARM) && arm_cl[32]) sat_q <= 1'b1;
      if ((state_q == ST_HEAD_W) && div_done) heading_q <= div_rem[19:0];
      if ((state_q == ST_MULX_W) && mul_done) begin
        x_q <= pos_cl[31:0];
        if (pos_cl[32]) sat_q <= 1'b1;
      end
      if ((state_q == ST_MULY_W) && mul_done) begin
        y_q <= pos_cl[31:0];
        if (pos_cl[32]) sat_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dl_q <= 33'($signed(s_axis_tdata[15:0]) * $signed({1'b0, ts_q}));
      dr_q <= 33'($signed(s_axis_tdata[31:16]) * $signed({1'b0, ts_q}));
    end
    if ((state_q == ST_ALPHA_W) && div_done) begin
      alpha_q    <= div_quot;
      straight_q <= (div_quot == '0);
    end
    if ((state_q == ST_SC0_W) && cor_done) begin
      s0_q <= cor_sin;
      c0_q <= cor_cos;
    end
    if ((state_q == ST_RAD_W) && div_done) radius_q <= div_quot;
    if (state_q == ST_ARM) arm_q <= arm_cl[31:0];
    if (out_load) begin
      m_data_q <= {4'b0000, heading_q, y_q, x_q};
      m_user_q <= sat_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  ddo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (heading_q),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  ddo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  `DDO_ASSERT(a_heading_range, clk_i, rst_ni, (heading_q <= 20'sd411774) && (heading_q >= -20'sd411774), "heading left its range")
  `DDO_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(m_valid_q) |-> $past(state_q == ST_DONE), "result shown outside done")
  `DDO_ASSERT(a_div_done_wait, clk_i, rst_ni, div_done |-> (state_q == ST_ALPHA_W || state_q == ST_RAD_W || state_q == ST_HEAD_W), "divider finished unexpectedly")
  `DDO_ASSERT(a_accept_starts, clk_i, rst_ni, in_acc |=> (state_q == ST_ALPHA), "accepted request did not start")
  `DDO_ASSERT_NEVER(a_units_overlap, clk_i, rst_ni, cor_done && mul_done, "cordic and multiplier overlap")

endmodule
